>>> hw/rtl/fsg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Floor span generator package
// Shared constants, the sequencer state type and the span record.
// ----------------------------------------------------------------------------
package fsg_pkg;

    localparam int MAX_ROWS     = 64;
    localparam int MAX_COLUMNS  = 512;
    localparam int HEIGHT_SHIFT = 3;

    localparam int HEIGHT_W  = 15;
    localparam int HROW_W    = HEIGHT_W - HEIGHT_SHIFT;
    localparam int ROW_W     = $clog2(MAX_ROWS) + 1;
    localparam int ROW_IDX_W = $clog2(MAX_ROWS);
    localparam int COL_W     = 9;
    localparam int SROW_W    = 6;

    localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(MAX_ROWS);
    localparam logic [COL_W-1:0] COL_LAST  = COL_W'(MAX_COLUMNS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OPEN,
        ST_CLOSE
    } fsg_state_t;

    typedef struct packed {
        logic [SROW_W-1:0] row;
        logic [COL_W-1:0]  first_col;
        logic [COL_W-1:0]  last_col;
        logic              last;
    } span_t;

endpackage
`default_nettype wire

>>> hw/rtl/fsg_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fsg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> hw/rtl/fsg_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Floor span sequencer
// Steps a shared row counter one row per cycle, unless spans stall: opens rows
// by writing start columns, or closes rows by reading them back as spans.
// ----------------------------------------------------------------------------
module fsg_core
    import fsg_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [ROW_W-1:0]    half_height,
    input  wire logic                in_valid,
    output      logic                in_ready,
    input  wire logic [HEIGHT_W-1:0] wall_height,
    input  wire logic                frame_end,
    output      logic                span_valid,
    input  wire logic                span_ready,
    output      span_t               span
);

    fsg_state_t       state_reg, state_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [ROW_W-1:0] limit_reg, limit_next;
    logic [ROW_W-1:0] open_reg, open_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [COL_W-1:0] cur_col_reg, cur_col_next;

    logic [ROW_W-1:0]  half_eff;
    logic [ROW_W-1:0]  orow;
    logic [ROW_W-1:0]  first;
    logic [ROW_W-1:0]  row_inc;
    logic [ROW_W-1:0]  hclamp;
    logic [HROW_W-1:0] hrow;
    logic              we;
    logic [COL_W-1:0]  rdata;

    assign half_eff = (half_height > ROW_LIMIT) ? ROW_LIMIT : half_height;
    assign orow     = (col_reg == '0) ? half_eff : open_reg;
    assign first    = (orow == '0) ? ROW_W'(1) : orow;
    assign row_inc  = row_reg + ROW_W'(1);
    assign hrow     = HROW_W'(wall_height >> HEIGHT_SHIFT);
    assign hclamp   = (hrow > HROW_W'(half_eff)) ? half_eff : ROW_W'(hrow);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            open_reg  <= ROW_LIMIT;
            col_reg   <= '0;
        end else begin
            state_reg <= state_next;
            open_reg  <= open_next;
            col_reg   <= col_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg     <= row_next;
        limit_reg   <= limit_next;
        cur_col_reg <= cur_col_next;
    end

    always_comb begin
        state_next   = state_reg;
        row_next     = row_reg;
        limit_next   = limit_reg;
        open_next    = open_reg;
        col_next     = col_reg;
        cur_col_next = cur_col_reg;
        in_ready     = 1'b0;
        span_valid   = 1'b0;
        we           = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cur_col_next = col_reg;
                    if (frame_end) begin
                        col_next  = '0;
                        open_next = half_eff;
                        if (first < half_eff) begin
                            row_next   = first;
                            limit_next = half_eff;
                            state_next = ST_CLOSE;
                        end
                    end else begin
                        if (col_reg != COL_LAST) begin
                            col_next = col_reg + COL_W'(1);
                        end
                        if (hrow < HROW_W'(orow)) begin
                            open_next  = ROW_W'(hrow);
                            row_next   = orow - ROW_W'(1);
                            limit_next = ROW_W'(hrow);
                            state_next = ST_OPEN;
                        end else if (hclamp > orow) begin
                            open_next = hclamp;
                            if (first < hclamp) begin
                                row_next   = first;
                                limit_next = hclamp;
                                state_next = ST_CLOSE;
                            end
                        end else begin
                            open_next = orow;
                        end
                    end
                end
            end
            ST_OPEN: begin
                we = 1'b1;
                if (row_reg == limit_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    row_next = row_reg - ROW_W'(1);
                end
            end
            ST_CLOSE: begin
                span_valid = 1'b1;
                if (span_ready) begin
                    if (row_inc == limit_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        row_next = row_inc;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign span.row       = SROW_W'(row_reg);
    assign span.first_col = rdata;
    assign span.last_col  = cur_col_reg - COL_W'(1);
    assign span.last      = (row_inc == limit_reg);

    fsg_ram #(
        .WIDTH(COL_W),
        .DEPTH(MAX_ROWS)
    ) u_start_ram (
        .aclk (aclk),
        .we   (we),
        .waddr(row_reg[ROW_IDX_W-1:0]),
        .wdata(cur_col_reg),
        .raddr(row_next[ROW_IDX_W-1:0]),
        .rdata(rdata)
    );

endmodule
`default_nettype wire

>>> hw/rtl/floor_span_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Floor span generator
// Turns per-column wall heights into floor spans, one per closed row above row 0.
//
// Each input transfer carries one column's raw wall height; s_tlast marks a
// frame-end transfer, which closes all open rows at the last column and
// rewinds to column 0. Each output transfer is one span; m_tlast marks the
// last span caused by an input transfer. The user must write the half view
// height through cfg_we/cfg_wdata only while the block is idle; the block
// itself does not enforce this. An input that causes no row change leaves
// the sequencer idle; a falling height makes it open rows one by one, and
// a rising height or a frame end makes it close rows, emitting one span per
// closed row. The sequencer steps one row per cycle through the start-column
// RAM. s_tready is low while the sequencer works. A stalled receiver holds
// the span in the output register and pauses the sequencer. Reset sets the
// half height to 64, the column to 0 and the output to empty; the start
// column RAM is not cleared.
// ----------------------------------------------------------------------------
module floor_span_generator
    import fsg_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [6:0]  cfg_wdata,  // half_height
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [15:0] s_tdata,    // wall_height[14:0], zero fill [15]
    input  wire logic        s_tlast,
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [23:0] m_tdata,    // span_row[5:0], span_start[14:6], span_end[23:15]
    output      logic        m_tlast
);

    logic [ROW_W-1:0] half_reg;
    logic             m_valid_reg;
    logic [23:0]      m_data_reg;
    logic             m_last_reg;
    logic             span_valid;
    logic             span_ready;
    span_t            span;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg <= ROW_LIMIT;
        end else if (cfg_we) begin
            half_reg <= cfg_wdata;
        end
    end

    assign span_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (span_ready) begin
            m_valid_reg <= span_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (span_ready && span_valid) begin
            m_data_reg <= {span.last_col, span.first_col, span.row};
            m_last_reg <= span.last;
        end
    end

    fsg_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .half_height(half_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .wall_height(s_tdata[HEIGHT_W-1:0]),
        .frame_end  (s_tlast),
        .span_valid (span_valid),
        .span_ready (span_ready),
        .span       (span)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule
`default_nettype wire

>>> test/floor_span_generator_tb.sv
// ----------------------------------------------------------------------------
// Floor span generator testbench
// Sends column heights and frame ends with random bursts and gaps, stalls the
// span output on a changing pattern, predicts every span from a model of the
// row store and open row, and compares each span transfer field by field.
// ----------------------------------------------------------------------------
module floor_span_generator_tb;
    import fsg_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_WAIT  = 80;
    localparam int HOLD_CYCLES  = 600;
    localparam int RANDOM_ITEMS = 130;
    localparam int LONG_FRAME   = 40;

    class floor_span_scoreboard;
        span_t       expected_spans[$];
        int unsigned errors;
        logic [6:0]  half_reg;
        int          open_row;
        int          column_index;
        logic [8:0]  start_col[MAX_ROWS];
        bit          start_known[MAX_ROWS];

        function new();
            half_reg = 7'd64;
            column_index = 0;
            open_row = 64;
            errors = 0;
            foreach (start_known[r]) start_known[r] = 1'b0;
        endfunction

        function int rows_for(logic [6:0] value);
            return (value > MAX_ROWS) ? MAX_ROWS : int'(value);
        endfunction

        function int pending();
            return expected_spans.size();
        endfunction

        function void write_half(logic [6:0] value);
            half_reg = value;
        endfunction

        // Mid-frame, a larger half height must not reach rows never stored.
        function logic [6:0] safe_half(logic [6:0] value);
            logic [6:0] v;
            bit ok;
            v = value;
            if (column_index == 0) return v;
            forever begin
                ok = 1'b1;
                for (int r = open_row; r < rows_for(v); r++) begin
                    if (!start_known[r]) ok = 1'b0;
                end
                if (ok) return v;
                v = v - 7'd1;
            end
        endfunction

        function void close_rows(int limit, logic [8:0] end_col);
            span_t s;
            while (open_row < limit) begin
                if (open_row > 0 && open_row < MAX_ROWS) begin
                    s.row = open_row[5:0];
                    s.first_col = start_col[open_row];
                    s.last_col = end_col;
                    s.last = 1'b0;
                    expected_spans.push_back(s);
                end
                open_row++;
            end
        endfunction

        function void note_column(logic [14:0] height, logic frame_end);
            int half;
            int col;
            int h;
            int first;
            half = rows_for(half_reg);
            first = expected_spans.size();
            if (column_index == 0) open_row = half;
            col = column_index;
            if (frame_end) begin
                close_rows(half, col[8:0] - 9'd1);
                column_index = 0;
                open_row = half;
            end else begin
                h = int'(height) >> HEIGHT_SHIFT;
                if (h < open_row) begin
                    do begin
                        open_row--;
                        if (open_row < MAX_ROWS) begin
                            start_col[open_row] = col[8:0];
                            start_known[open_row] = 1'b1;
                        end
                    end while (open_row > h);
                end else if (h > open_row) begin
                    if (h > half) h = half;
                    close_rows(h, col[8:0] - 9'd1);
                end
                if (column_index < MAX_COLUMNS - 1) column_index++;
            end
            if (expected_spans.size() > first) expected_spans[$].last = 1'b1;
        endfunction

        function void check_span(logic [23:0] data, logic last);
            span_t s;
            if (expected_spans.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("span error: unexpected row %0d start %0d end %0d last %0b",
                             data[5:0], data[14:6], data[23:15], last);
                return;
            end
            s = expected_spans.pop_front();
            if (data[5:0] !== s.row || data[14:6] !== s.first_col
                    || data[23:15] !== s.last_col || last !== s.last) begin
                errors++;
                if (errors <= 10)
                    $display("span error: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                             s.row, s.first_col, s.last_col, s.last,
                             data[5:0], data[14:6], data[23:15], last);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [6:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;

    floor_span_scoreboard sb = new();
    int unsigned cycle_count = 0;
    int          burst_left = 0;
    bit          long_hold = 1'b0;

    floor_span_generator dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_span(m_tdata, m_tlast);
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("floor_span_generator: mismatch");
        $finish;
    end

    initial begin : span_receiver
        int mode;
        int left;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(20, 200);
            while (left > 0) begin
                if (long_hold) begin
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge aclk);
                    long_hold = 1'b0;
                end
                case (mode)
                    0: begin
                        m_tready <= 1'b1;
                    end
                    1: begin
                        m_tready <= ($urandom_range(0, 1) == 1);
                    end
                    2: begin
                        m_tready <= ($urandom_range(0, 7) != 0);
                    end
                    default: begin
                        m_tready <= ((left % 16) >= 5);
                    end
                endcase
                @(negedge aclk);
                left--;
            end
        end
    end

    task automatic send_column(input logic [14:0] height, input logic frame_end);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, height};
        s_tlast <= frame_end;
        do @(posedge aclk); while (!s_tready);
        sb.note_column(height, frame_end);
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_WAIT) @(negedge aclk);
    endtask

    task automatic set_half(input logic [6:0] value);
        logic [6:0] v;
        settle();
        v = sb.safe_half(value);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        sb.write_half(v);
    endtask

    function automatic logic [14:0] pick_height();
        case ($urandom_range(0, 9))
            0: return 15'($urandom_range(0, 32767));
            1: return 15'($urandom_range(0, 7));
            default: return 15'(($urandom_range(0, 70) << HEIGHT_SHIFT) | $urandom_range(0, 7));
        endcase
    endfunction

    function automatic logic [6:0] pick_half();
        case ($urandom_range(0, 9))
            0: return 7'd0;
            1: return 7'd1;
            2: return 7'd64;
            3: return 7'($urandom_range(65, 127));
            default: return 7'($urandom_range(1, 64));
        endcase
    endfunction

    initial begin : stimulus
        int sent;
        int phase_len;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 7'd0;
        s_tvalid = 1'b0;
        s_tdata = 16'd0;
        s_tlast = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_column(15'd0, 1'b0);
        send_column(15'h7FFF, 1'b0);
        send_column(15'd80, 1'b0);
        send_column(15'd7, 1'b0);
        send_column(15'd43, 1'b0);
        send_column(15'd512, 1'b0);
        send_column(15'd520, 1'b0);
        send_column(15'd200, 1'b0);
        send_column(15'd0, 1'b1);
        send_column(15'd0, 1'b1);

        set_half(7'd1);
        send_column(15'd0, 1'b0);
        send_column(15'd8, 1'b0);
        send_column(15'd3, 1'b0);
        send_column(15'd0, 1'b1);

        set_half(7'd0);
        send_column(15'd0, 1'b0);
        send_column(15'd800, 1'b0);
        send_column(15'd0, 1'b1);

        set_half(7'd127);
        send_column(15'd16, 1'b0);
        set_half(7'd20);
        send_column(15'd400, 1'b0);
        send_column(15'h7FFF, 1'b1);

        // A longer frame at the full half height.
        set_half(7'd64);
        for (int i = 0; i < LONG_FRAME; i++) send_column(pick_height(), 1'b0);
        send_column(pick_height(), 1'b1);

        long_hold = 1'b1;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase_len = $urandom_range(10, 40);
            for (int i = 0; i < phase_len; i++) begin
                send_column(pick_height(), ($urandom_range(0, 9) == 0));
                sent++;
            end
            set_half(pick_half());
        end
        send_column(pick_height(), 1'b1);

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("floor_span_generator: match");
        end else begin
            $display("floor_span_generator: mismatch");
        end
        $finish;
    end

endmodule
